/* rtl/core/assert_macros.svh */
// assertion macros shared by the checker files
// each macro expects signals named clk and rst_n in the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define ACS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acs checker: property violated");

// consequent checked in the cycle after the antecedent
`define ACS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acs checker: property violated");

`endif

/* rtl/core/acs_pkg.sv */
// shared types and codes for the arc consistency solver
// no dependencies
package acs_pkg;

  // input item function codes
  typedef enum logic [1:0] {
    FUNC_UNARY = 2'd0,
    FUNC_ROW   = 2'd1,
    FUNC_SOLVE = 2'd2,
    FUNC_CLEAR = 2'd3
  } acs_func_t;

  // configuration register indexes
  localparam logic CFG_VAR_COUNT   = 1'b0;
  localparam logic CFG_VALUE_COUNT = 1'b1;

  localparam int CFG_DATA_W = 5;
  localparam int FIELD_W    = 16;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LOADPEND,
    S_PICK_ROW,
    S_PICK_COL,
    S_SRC,
    S_DST,
    S_REV,
    S_WB,
    S_EMIT
  } acs_state_t;

  // control from the sequencer to the revise unit
  typedef struct packed {
    logic ld_src;
    logic ld_dst;
    logic cmp;
  } acs_rev_ctrl_t;

endpackage

/* rtl/core/acs_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module acs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/acs_revise.sv */
// revise unit: holds source and target domains and strikes unsupported values
// one relation row compared per cycle; depends on acs_pkg
module acs_revise #(
  parameter int MAX_DOMAIN = 16
) (
  input  logic                          clk,
  input  acs_pkg::acs_rev_ctrl_t        ctrl,
  input  logic [MAX_DOMAIN-1:0]         dom_rd,
  input  logic [MAX_DOMAIN-1:0]         vmask,
  input  logic [MAX_DOMAIN-1:0]         row_data,
  input  logic [$clog2(MAX_DOMAIN)-1:0] idx,
  output logic [MAX_DOMAIN-1:0]         keep,
  output logic                          shrunk,
  output logic                          empty
);

  logic [MAX_DOMAIN-1:0] sdom_r;
  logic [MAX_DOMAIN-1:0] tdom_r;
  logic [MAX_DOMAIN-1:0] keep_r;

  // capture domains, then clear target values without support
  always_ff @(posedge clk) begin
    if (ctrl.ld_src) begin
      sdom_r <= dom_rd & vmask;
    end
    if (ctrl.ld_dst) begin
      tdom_r <= dom_rd & vmask;
      keep_r <= dom_rd & vmask;
    end else if (ctrl.cmp) begin
      if ((row_data & sdom_r) == '0) begin
        keep_r[idx] <= 1'b0;
      end
    end
  end

  assign keep   = keep_r;
  assign shrunk = (keep_r != tdom_r);
  assign empty  = (keep_r == '0);

endmodule

/* rtl/core/arc_consistency_solver.sv */
// Loads (unary mask, relation row) are taken without leaving the idle state; clear
// problem runs one relation memory sweep of 2**(2*clog2(MAX_VARS)+clog2(MAX_DOMAIN))
// rows (4096 by default). Solve: a check step per variable in use, a pending-arc load
// step, then per revised arc in the shared revise unit (arc pick, two domain reads,
// one row per cycle, write-back), one final arc pick that finds nothing pending, then
// one result per variable as the output takes them. in_stall is high meanwhile.
// Reset (rst_n low, synchronous) clears control state and runs the same memory sweep.
module arc_consistency_solver #(
  parameter int MAX_VARS   = 16,
  parameter int MAX_DOMAIN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_src_var,
  input  logic [3:0]  in_dst_var,
  input  logic [3:0]  in_dst_value,
  input  logic [15:0] in_allowed_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_var_index,
  output logic [15:0] out_domain_out,
  output logic        out_failed,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);

  localparam int VW    = $clog2(MAX_VARS);
  localparam int DIW   = $clog2(MAX_DOMAIN);
  localparam int NW    = $clog2(MAX_VARS + 1);
  localparam int DSW   = $clog2(MAX_DOMAIN + 1);
  localparam int AW    = 2 * VW + DIW;
  localparam int DEPTH = 1 << AW;
  localparam int FW    = acs_pkg::FIELD_W;

  // configuration registers
  logic [acs_pkg::CFG_DATA_W-1:0] var_count_r;
  logic [acs_pkg::CFG_DATA_W-1:0] value_count_r;
  logic [NW-1:0]                  nv_w;
  logic [DSW-1:0]                 ds_w;
  logic [MAX_DOMAIN-1:0]          vmask;

  // sequencer and datapath state
  acs_pkg::acs_state_t state_r, state_nxt;
  logic [VW-1:0]   var_cnt_r, var_cnt_nxt;
  logic [VW-1:0]   src_r, src_nxt;
  logic [VW-1:0]   dst_r, dst_nxt;
  logic [DIW-1:0]  idx_r, idx_nxt;
  logic            fail_r, fail_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [MAX_VARS-1:0][MAX_VARS-1:0] pres_r, pres_nxt;
  logic [MAX_VARS-1:0][MAX_VARS-1:0] pend_r, pend_nxt;
  logic [MAX_DOMAIN-1:0] dom_r [MAX_VARS];

  // output register
  logic        out_valid_r;
  logic [3:0]  out_var_r;
  logic [FW-1:0] out_dom_r;
  logic        out_fail_r;
  logic        out_last_r;

  // domain store access
  logic [VW-1:0]         dom_raddr;
  logic [MAX_DOMAIN-1:0] dom_rd;
  logic                  dom_we;
  logic [VW-1:0]         dom_waddr;
  logic [MAX_DOMAIN-1:0] dom_wdata;
  logic                  dom_set_all;

  // relation memory access
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [MAX_DOMAIN-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [MAX_DOMAIN-1:0] ram_rdata;
  logic [DIW-1:0]        idx_inc;
  logic [DIW-1:0]        rd_idx;

  // misc control
  acs_pkg::acs_func_t     in_fn;
  acs_pkg::acs_rev_ctrl_t rev_ctrl;
  logic                   in_fire;
  logic                   slot_free;
  logic                   var_last;
  logic                   rev_last;
  logic                   chk_empty;
  logic [MAX_VARS-1:0]    row_any;
  logic                   any_pend;
  logic [VW-1:0]          row_sel;
  logic [VW-1:0]          col_sel;
  logic [MAX_DOMAIN-1:0]  keep;
  logic                   shrunk;
  logic                   empty;
  logic                   src_ok;
  logic                   dst_ok;
  logic                   val_ok;
  logic [MAX_DOMAIN+FW-1:0] in_mask_ext;
  logic [MAX_DOMAIN+FW-1:0] in_row_ext;
  logic [MAX_DOMAIN+FW-1:0] dom_out_ext;

  // saturate configuration to its usable range
  always_comb begin
    if (var_count_r == '0) begin
      nv_w = NW'(1);
    end else if (32'(var_count_r) > MAX_VARS) begin
      nv_w = NW'(MAX_VARS);
    end else begin
      nv_w = NW'(var_count_r);
    end
    if (value_count_r == '0) begin
      ds_w = DSW'(1);
    end else if (32'(value_count_r) > MAX_DOMAIN) begin
      ds_w = DSW'(MAX_DOMAIN);
    end else begin
      ds_w = DSW'(value_count_r);
    end
  end

  // mask of value bits in use
  always_comb begin
    for (int i = 0; i < MAX_DOMAIN; i++) begin
      vmask[i] = (32'(i) < 32'(ds_w));
    end
  end

  // configuration write channel
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r   <= acs_pkg::CFG_DATA_W'(16);
      value_count_r <= acs_pkg::CFG_DATA_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        acs_pkg::CFG_VAR_COUNT:   var_count_r   <= cfg_wdata;
        acs_pkg::CFG_VALUE_COUNT: value_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input decode
  assign in_stall = (state_r != acs_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign in_fn    = acs_pkg::acs_func_t'(in_func);
  assign src_ok   = (32'(in_src_var) < 32'(nv_w));
  assign dst_ok   = (32'(in_dst_var) < 32'(nv_w));
  assign val_ok   = (32'(in_dst_value) < 32'(ds_w));
  assign in_mask_ext = {{MAX_DOMAIN{1'b1}}, in_allowed_bits};
  assign in_row_ext  = {{MAX_DOMAIN{1'b0}}, in_allowed_bits};

  // shared domain read port
  always_comb begin
    unique case (state_r)
      acs_pkg::S_SRC: dom_raddr = src_r;
      acs_pkg::S_DST: dom_raddr = dst_r;
      acs_pkg::S_IDLE: dom_raddr = VW'(in_src_var);
      default: dom_raddr = var_cnt_r;
    endcase
  end
  assign dom_rd      = dom_r[dom_raddr];
  assign chk_empty   = ((dom_rd & vmask) == '0);
  assign dom_out_ext = {{FW{1'b0}}, dom_rd & vmask};

  // counters and limits
  assign var_last  = (32'(var_cnt_r) + 1 == 32'(nv_w));
  assign rev_last  = (32'(idx_r) + 1 == 32'(ds_w));
  assign idx_inc   = DIW'(32'(idx_r) + 1);
  assign rd_idx    = (state_r == acs_pkg::S_DST) ? '0 : idx_inc;
  assign ram_raddr = {src_r, dst_r, rd_idx};
  assign slot_free = !out_valid_r || !out_stall;

  // lowest pending arc: row first, then column within the row
  always_comb begin
    row_sel = '0;
    col_sel = '0;
    for (int i = 0; i < MAX_VARS; i++) begin
      row_any[i] = |pend_r[i];
    end
    for (int i = MAX_VARS - 1; i >= 0; i--) begin
      if (row_any[i]) begin
        row_sel = VW'(i);
      end
      if (pend_r[src_r][i]) begin
        col_sel = VW'(i);
      end
    end
  end
  assign any_pend = |row_any;

  // revise unit
  assign rev_ctrl.ld_src = (state_r == acs_pkg::S_SRC);
  assign rev_ctrl.ld_dst = (state_r == acs_pkg::S_DST);
  assign rev_ctrl.cmp    = (state_r == acs_pkg::S_REV);

  acs_revise #(
    .MAX_DOMAIN (MAX_DOMAIN)
  ) u_revise (
    .clk      (clk),
    .ctrl     (rev_ctrl),
    .dom_rd   (dom_rd),
    .vmask    (vmask),
    .row_data (ram_rdata),
    .idx      (idx_r),
    .keep     (keep),
    .shrunk   (shrunk),
    .empty    (empty)
  );

  // relation row memory
  acs_ram #(
    .WIDTH (MAX_DOMAIN),
    .DEPTH (DEPTH)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acs_pkg::S_CLEAR: begin
        if (clr_addr_r == '1) state_nxt = acs_pkg::S_IDLE;
      end
      acs_pkg::S_IDLE: begin
        if (in_fire && in_fn == acs_pkg::FUNC_SOLVE) state_nxt = acs_pkg::S_CHECK;
        if (in_fire && in_fn == acs_pkg::FUNC_CLEAR) state_nxt = acs_pkg::S_CLEAR;
      end
      acs_pkg::S_CHECK: begin
        if (var_last) begin
          state_nxt = (fail_r || chk_empty) ? acs_pkg::S_EMIT : acs_pkg::S_LOADPEND;
        end
      end
      acs_pkg::S_LOADPEND: state_nxt = acs_pkg::S_PICK_ROW;
      acs_pkg::S_PICK_ROW: begin
        state_nxt = any_pend ? acs_pkg::S_PICK_COL : acs_pkg::S_EMIT;
      end
      acs_pkg::S_PICK_COL: state_nxt = acs_pkg::S_SRC;
      acs_pkg::S_SRC:      state_nxt = acs_pkg::S_DST;
      acs_pkg::S_DST:      state_nxt = acs_pkg::S_REV;
      acs_pkg::S_REV: begin
        if (rev_last) state_nxt = acs_pkg::S_WB;
      end
      acs_pkg::S_WB: begin
        state_nxt = (shrunk && empty) ? acs_pkg::S_EMIT : acs_pkg::S_PICK_ROW;
      end
      acs_pkg::S_EMIT: begin
        if (slot_free && var_last) state_nxt = acs_pkg::S_IDLE;
      end
      default: state_nxt = acs_pkg::S_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    var_cnt_nxt  = var_cnt_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    idx_nxt      = idx_r;
    fail_nxt     = fail_r;
    clr_addr_nxt = clr_addr_r;
    pres_nxt     = pres_r;
    pend_nxt     = pend_r;
    dom_we       = 1'b0;
    dom_waddr    = dst_r;
    dom_wdata    = keep;
    dom_set_all  = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = {VW'(in_src_var), VW'(in_dst_var), DIW'(in_dst_value)};
    ram_wdata    = in_row_ext[MAX_DOMAIN-1:0];
    unique case (state_r)
      acs_pkg::S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = AW'(32'(clr_addr_r) + 1);
      end
      acs_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_fn)
            acs_pkg::FUNC_UNARY: begin
              if (src_ok) begin
                dom_we    = 1'b1;
                dom_waddr = VW'(in_src_var);
                dom_wdata = dom_rd & in_mask_ext[MAX_DOMAIN-1:0];
              end
            end
            acs_pkg::FUNC_ROW: begin
              if (src_ok && dst_ok && val_ok) begin
                ram_we = 1'b1;
                pres_nxt[VW'(in_src_var)][VW'(in_dst_var)] = 1'b1;
              end
            end
            acs_pkg::FUNC_SOLVE: begin
              fail_nxt    = 1'b0;
              pend_nxt    = '0;
              var_cnt_nxt = '0;
            end
            acs_pkg::FUNC_CLEAR: begin
              dom_set_all  = 1'b1;
              pres_nxt     = '0;
              pend_nxt     = '0;
              fail_nxt     = 1'b0;
              clr_addr_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      acs_pkg::S_CHECK: begin
        if (chk_empty) fail_nxt = 1'b1;
        var_cnt_nxt = var_last ? '0 : VW'(32'(var_cnt_r) + 1);
      end
      acs_pkg::S_LOADPEND: begin
        for (int s = 0; s < MAX_VARS; s++) begin
          for (int t = 0; t < MAX_VARS; t++) begin
            pend_nxt[s][t] = pres_r[s][t] && (32'(s) < 32'(nv_w)) && (32'(t) < 32'(nv_w));
          end
        end
      end
      acs_pkg::S_PICK_ROW: begin
        src_nxt     = row_sel;
        var_cnt_nxt = '0;
      end
      acs_pkg::S_PICK_COL: begin
        dst_nxt                 = col_sel;
        pend_nxt[src_r][col_sel] = 1'b0;
      end
      acs_pkg::S_DST: begin
        idx_nxt = '0;
      end
      acs_pkg::S_REV: begin
        idx_nxt = idx_inc;
      end
      acs_pkg::S_WB: begin
        if (shrunk) begin
          dom_we = 1'b1;
          if (empty) begin
            fail_nxt = 1'b1;
            pend_nxt = '0;
          end else begin
            // re-queue arcs leaving the reduced variable, except back to the source
            for (int k = 0; k < MAX_VARS; k++) begin
              if ((32'(k) < 32'(nv_w)) && (VW'(k) != src_r) && pres_r[dst_r][k]) begin
                pend_nxt[dst_r][k] = 1'b1;
              end
            end
          end
        end
        var_cnt_nxt = '0;
      end
      acs_pkg::S_EMIT: begin
        if (slot_free) var_cnt_nxt = VW'(32'(var_cnt_r) + 1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= acs_pkg::S_CLEAR;
      clr_addr_r <= '0;
      fail_r     <= 1'b0;
      pres_r     <= '0;
      pend_r     <= '0;
      var_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      fail_r     <= fail_nxt;
      pres_r     <= pres_nxt;
      pend_r     <= pend_nxt;
      var_cnt_r  <= var_cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    dst_r <= dst_nxt;
    idx_r <= idx_nxt;
  end

  // domain store
  always_ff @(posedge clk) begin
    if (!rst_n || dom_set_all) begin
      for (int v = 0; v < MAX_VARS; v++) begin
        dom_r[v] <= '1;
      end
    end else if (dom_we) begin
      dom_r[dom_waddr] <= dom_wdata;
    end
  end

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == acs_pkg::S_EMIT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == acs_pkg::S_EMIT && slot_free) begin
      out_var_r  <= 4'(var_cnt_r);
      out_dom_r  <= dom_out_ext[FW-1:0];
      out_fail_r <= fail_r;
      out_last_r <= var_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_var_index  = out_var_r;
  assign out_domain_out = out_dom_r;
  assign out_failed     = out_fail_r;
  assign out_last       = out_last_r;

endmodule

/* rtl/core/acs_checker.sv */
// port-level checker for the arc consistency solver, bound to the top level
// depends on assert_macros.svh and acs_pkg
`include "assert_macros.svh"

module acs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_var_index,
  input logic [15:0] out_domain_out,
  input logic        out_last
);

  // a solve transaction keeps the input side busy on the next cycle
  `ACS_ASSERT_NEXT(a_solve_busy, in_valid && !in_stall && in_func == acs_pkg::FUNC_SOLVE, in_stall)

  // while results of a run remain, no new item is taken
  `ACS_ASSERT_NOW(a_emit_busy, out_valid && !out_last, in_stall)

  // results of a run come back to back, in ascending variable order
  `ACS_ASSERT_NEXT(a_emit_next, out_valid && !out_stall && !out_last, out_valid && out_var_index == $past(out_var_index) + 4'd1)

  // a stalled result holds
  `ACS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_domain_out) && $stable(out_var_index))

endmodule

bind arc_consistency_solver acs_checker u_acs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_var_index  (out_var_index),
  .out_domain_out (out_domain_out),
  .out_last       (out_last)
);

/* verif/tb_top.sv */
// testbench for the arc consistency solver: a directed set, then random problems under
// several register settings, with every result checked against an in-bench predictor
// depends on rtl/core/acs_pkg.sv and rtl/core/arc_consistency_solver.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int NV_MAX       = 16;
  localparam int DS_MAX       = 16;
  localparam int IDLE_WAIT    = 4200;    // covers a full clear sweep of the relation memory
  localparam int WATCHDOG_MAX = 500000;

  typedef struct packed {
    logic [3:0]  var_index;
    logic [15:0] domain_out;
    logic        failed;
    logic        last;
  } domain_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  acs_pkg::acs_func_t in_func = acs_pkg::FUNC_CLEAR;
  logic [3:0]  in_src_var = '0;
  logic [3:0]  in_dst_var = '0;
  logic [3:0]  in_dst_value = '0;
  logic [15:0] in_allowed_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_var_index;
  logic [15:0] out_domain_out;
  logic        out_failed;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = acs_pkg::CFG_VAR_COUNT;
  logic [4:0]  cfg_wdata = '0;

  arc_consistency_solver u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_src_var(in_src_var), .in_dst_var(in_dst_var), .in_dst_value(in_dst_value),
    .in_allowed_bits(in_allowed_bits),
    .out_valid(out_valid), .out_stall(out_stall), .out_var_index(out_var_index),
    .out_domain_out(out_domain_out), .out_failed(out_failed), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic [15:0]    dom_q [NV_MAX];
  logic [15:0]    rel_rows [NV_MAX*NV_MAX*DS_MAX];
  logic           arc_on [NV_MAX*NV_MAX];
  logic           arc_wait [NV_MAX*NV_MAX];
  logic           solve_failed;
  logic [4:0]     nv_reg = 5'd16;
  logic [4:0]     ds_reg = 5'd16;
  domain_report_t domain_fifo [$];
  int             err_count = 0;
  bit             jitter_on = 1'b1;

  function automatic int eff_nv();
    if (nv_reg == 0) return 1;
    return (nv_reg > NV_MAX) ? NV_MAX : int'(nv_reg);
  endfunction

  function automatic int eff_ds();
    if (ds_reg == 0) return 1;
    return (ds_reg > DS_MAX) ? DS_MAX : int'(ds_reg);
  endfunction

  function automatic logic [15:0] value_mask();
    return (eff_ds() >= 16) ? 16'hFFFF : 16'((32'd1 << eff_ds()) - 1);
  endfunction

  function automatic void wipe_problem();
    foreach (dom_q[i]) dom_q[i] = 16'hFFFF;
    foreach (rel_rows[i]) rel_rows[i] = '0;
    foreach (arc_on[i]) begin
      arc_on[i] = 1'b0;
      arc_wait[i] = 1'b0;
    end
    solve_failed = 1'b0;
  endfunction

  // one arc revision, returns 1 when the target domain shrank
  function automatic bit revise_arc(int s, int t);
    logic [15:0] vm, sdom, tdom, keep;
    int          arc;
    vm = value_mask();
    sdom = dom_q[s] & vm;
    tdom = dom_q[t] & vm;
    keep = tdom;
    arc = s * NV_MAX + t;
    for (int i = 0; i < eff_ds(); i++)
      if (tdom[i] && ((rel_rows[arc*DS_MAX + i] & sdom) == 0)) keep[i] = 1'b0;
    if (keep == tdom) return 1'b0;
    dom_q[t] = keep;
    return 1'b1;
  endfunction

  function automatic void run_ac3();
    int nv, a, s, t;
    nv = eff_nv();
    solve_failed = 1'b0;
    foreach (arc_wait[i]) arc_wait[i] = 1'b0;
    for (int v = 0; v < nv; v++)
      if ((dom_q[v] & value_mask()) == 0) solve_failed = 1'b1;
    if (solve_failed) return;
    for (s = 0; s < nv; s++)
      for (t = 0; t < nv; t++) arc_wait[s*NV_MAX + t] = arc_on[s*NV_MAX + t];
    forever begin
      a = -1;
      for (int i = 0; i < NV_MAX*NV_MAX; i++)
        if (arc_wait[i]) begin
          a = i;
          break;
        end
      if (a < 0) break;
      arc_wait[a] = 1'b0;
      s = a / NV_MAX;
      t = a % NV_MAX;
      if (!revise_arc(s, t)) continue;
      if ((dom_q[t] & value_mask()) == 0) begin
        solve_failed = 1'b1;
        foreach (arc_wait[i]) arc_wait[i] = 1'b0;
        break;
      end
      for (int k = 0; k < nv; k++)
        if (k != s && arc_on[t*NV_MAX + k]) arc_wait[t*NV_MAX + k] = 1'b1;
    end
  endfunction

  // apply one accepted item to the predictor
  function automatic void predict_item(acs_pkg::acs_func_t f, int src, int dst, int val,
                                       logic [15:0] bits);
    domain_report_t r;
    case (f)
      acs_pkg::FUNC_UNARY: begin
        if (src < eff_nv()) dom_q[src] &= bits;
      end
      acs_pkg::FUNC_ROW: begin
        if (src < eff_nv() && dst < eff_nv() && val < eff_ds()) begin
          rel_rows[(src*NV_MAX + dst)*DS_MAX + val] = bits;
          arc_on[src*NV_MAX + dst] = 1'b1;
        end
      end
      acs_pkg::FUNC_SOLVE: begin
        run_ac3();
        for (int v = 0; v < eff_nv(); v++) begin
          r.var_index = 4'(v);
          r.domain_out = dom_q[v] & value_mask();
          r.failed = solve_failed;
          r.last = (v + 1 == eff_nv());
          domain_fifo.push_back(r);
        end
      end
      default: wipe_problem();
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // send one transaction; valid is left high so the next one can follow at once
  task automatic send_item(acs_pkg::acs_func_t f, int src, int dst, int val,
                           logic [15:0] bits);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_src_var <= 4'(src);
    in_dst_var <= 4'(dst);
    in_dst_value <= 4'(val);
    in_allowed_bits <= bits;
    do @(posedge clk); while (in_stall);
    predict_item(f, src, dst, val, bits);
  endtask

  // stop sending and wait for all results to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (domain_fifo.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [4:0] data);
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == acs_pkg::CFG_VAR_COUNT) nv_reg = data;
    else ds_reg = data;
  endtask

  task automatic set_problem_size(logic [4:0] nv, logic [4:0] ds);
    drain_results();
    write_reg(acs_pkg::CFG_VAR_COUNT, nv);
    write_reg(acs_pkg::CFG_VALUE_COUNT, ds);
  endtask

  // result checker
  always @(posedge clk) begin
    domain_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (domain_fifo.size() == 0) begin
        report_mismatch("unexpected result var", out_var_index, 0);
      end else begin
        want = domain_fifo.pop_front();
        if (out_var_index !== want.var_index)
          report_mismatch("var_index", out_var_index, want.var_index);
        if (out_domain_out !== want.domain_out)
          report_mismatch("domain_out", out_domain_out, want.domain_out);
        if (out_failed !== want.failed) report_mismatch("failed", out_failed, want.failed);
        if (out_last !== want.last) report_mismatch("last", out_last, want.last);
      end
    end
  end

  // receiver stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (!jitter_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any transaction
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("timeout");
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    set_problem_size(5'd4, 5'd4);
    send_item(acs_pkg::FUNC_CLEAR, 0, 0, 0, 16'h0000);
    send_item(acs_pkg::FUNC_UNARY, 0, 0, 0, 16'hFFFF);
    send_item(acs_pkg::FUNC_UNARY, 1, 0, 0, 16'h0006);
    send_item(acs_pkg::FUNC_ROW, 0, 1, 0, 16'h0001);
    send_item(acs_pkg::FUNC_ROW, 0, 1, 1, 16'h0002);
    send_item(acs_pkg::FUNC_ROW, 1, 0, 2, 16'h0004);
    // self arc
    send_item(acs_pkg::FUNC_ROW, 2, 2, 3, 16'h0008);
    // unused variable and value out of range, both ignored
    send_item(acs_pkg::FUNC_ROW, 15, 0, 0, 16'hFFFF);
    send_item(acs_pkg::FUNC_ROW, 0, 1, 15, 16'hFFFF);
    send_item(acs_pkg::FUNC_UNARY, 15, 0, 0, 16'h0000);
    send_item(acs_pkg::FUNC_SOLVE, 0, 0, 0, 16'h0000);
    // repeated solve on the reduced domains
    send_item(acs_pkg::FUNC_SOLVE, 15, 15, 15, 16'hFFFF);
    // empty domain before solving
    send_item(acs_pkg::FUNC_UNARY, 3, 0, 0, 16'h0000);
    send_item(acs_pkg::FUNC_SOLVE, 0, 0, 0, 16'h0000);
    // failure during revision
    send_item(acs_pkg::FUNC_CLEAR, 15, 15, 15, 16'hFFFF);
    send_item(acs_pkg::FUNC_UNARY, 0, 0, 0, 16'h0001);
    for (int k = 0; k < 4; k++) send_item(acs_pkg::FUNC_ROW, 0, 1, k, 16'h0002);
    send_item(acs_pkg::FUNC_ROW, 1, 2, 0, 16'hFFFF);
    send_item(acs_pkg::FUNC_SOLVE, 0, 0, 0, 16'h0000);
    send_item(acs_pkg::FUNC_SOLVE, 0, 0, 0, 16'h0000);
    drain_results();
  endtask

  // well-formed problems with random content, plus noise items
  task automatic run_random_problems(int items_goal);
    int          sent;
    int          nv, ds, n_rows;
    logic [15:0] bits;
    sent = 0;
    nv = eff_nv();
    ds = eff_ds();
    while (sent < items_goal) begin
      if ($urandom_range(0, 2) != 0) begin
        send_item(acs_pkg::FUNC_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), 16'($urandom));
        sent++;
      end
      repeat ($urandom_range(0, 2)) begin
        bits = 16'($urandom | $urandom);
        send_item(acs_pkg::FUNC_UNARY, $urandom_range(0, nv - 1), $urandom_range(0, 15),
                  $urandom_range(0, 15), bits);
        sent++;
      end
      n_rows = $urandom_range(1, 8);
      repeat (n_rows) begin
        bits = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom & $urandom);
        send_item(acs_pkg::FUNC_ROW, $urandom_range(0, nv - 1), $urandom_range(0, nv - 1),
                  $urandom_range(0, ds - 1), bits);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_item(acs_pkg::acs_func_t'($urandom_range(0, 1)), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 15), 16'($urandom));
        sent++;
      end
      send_item(acs_pkg::FUNC_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 15), 16'($urandom));
      sent++;
    end
  endtask

  task automatic test_register_extremes();
    set_problem_size(5'd0, 5'd0);
    run_random_problems(4);
    set_problem_size(5'd31, 5'd31);
    run_random_problems(10);
    set_problem_size(5'd1, 5'd16);
    run_random_problems(4);
    set_problem_size(5'd16, 5'd1);
    run_random_problems(4);
  endtask

  task automatic test_random_sizes();
    repeat (3) begin
      set_problem_size(5'($urandom_range(2, 6)), 5'($urandom_range(2, 8)));
      run_random_problems(6);
    end
  endtask

  task automatic test_steady_flow();
    set_problem_size(5'd3, 5'd3);
    jitter_on = 1'b0;
    run_random_problems(12);
    drain_results();
  endtask

  initial begin
    wipe_problem();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_random_sizes();
    test_steady_flow();
    repeat (50) @(posedge clk);
    if (domain_fifo.size() != 0)
      report_mismatch("results left over", domain_fifo.size(), 0);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
